@@ hw/rtl/efcd_pkg.sv @@
// Shared types and constants for the earliest-free counter dispatcher.
`default_nettype none
package efcd_pkg;

  localparam int ID_W        = 20;
  localparam int SVC_W       = 16;
  localparam int TIME_W      = 32;
  localparam int OIDX_W      = 5;
  localparam int CFG_W       = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 64;

  localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [SVC_W-1:0] svc;
    logic             last;
  } job_t;

  typedef struct packed {
    logic [TIME_W-1:0] fin_time;
    logic [OIDX_W-1:0] idx;
    logic [ID_W-1:0]   id;
    logic              last;
  } dep_t;

endpackage
`default_nettype wire

@@ hw/rtl/efcd_front.sv @@
// Input side: unpacks job words into a two-entry queue ahead of the dispatch engine.
`default_nettype none
module efcd_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [efcd_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  wire logic                              in_tlast,
  output logic                                   q_valid,
  output efcd_pkg::job_t                         q_job,
  input  wire logic                              q_ready
);
  import efcd_pkg::*;

  job_t       ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  job_t       in_job;

  assign in_job.id   = in_tdata[ID_W-1:0];
  assign in_job.svc  = in_tdata[ID_W+SVC_W-1:ID_W];
  assign in_job.last = in_tlast;

  assign in_tready = (cnt_r != 2'd2);
  assign q_valid   = (cnt_r != 2'd0);
  assign q_job     = ent_r[rd_ptr_r];

  assign push = in_tvalid && in_tready;
  assign pop  = q_valid && q_ready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_job;
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/efcd_engine.sv @@
// Dispatch engine: counter table, earliest-free scan, flush sequencing and output register.
`default_nettype none
module efcd_engine #(
  parameter int NUM_COUNTERS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic [efcd_pkg::CFG_W-1:0]  cfg_limit,
  input  wire logic                        q_valid,
  input  efcd_pkg::job_t                   q_job,
  output logic                             q_ready,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output efcd_pkg::dep_t                   out_dep
);
  import efcd_pkg::*;

  localparam int CNT_W = $clog2(NUM_COUNTERS + 1);
  localparam int IDX_W = (NUM_COUNTERS > 1) ? $clog2(NUM_COUNTERS) : 1;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_EMIT  = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [TIME_W-1:0] time_mem [NUM_COUNTERS];
  logic [ID_W-1:0]   id_mem   [NUM_COUNTERS];

  logic [1:0]              state_r, state_nxt;
  logic [NUM_COUNTERS-1:0] busy_r, busy_nxt;
  logic                    fl_r, fl_nxt;
  logic [CNT_W-1:0]        rd_cnt_r, rd_cnt_nxt;
  logic [CNT_W-1:0]        scan_end_r, scan_end_nxt;
  logic                    cmp_v_r, cmp_v_nxt;
  logic                    have_r, have_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic [IDX_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [TIME_W-1:0] rd_time_r;
  logic [ID_W-1:0]   rd_id_r;
  logic [TIME_W-1:0] best_time_r, best_time_nxt;
  logic [IDX_W-1:0]  best_idx_r, best_idx_nxt;
  logic [ID_W-1:0]   best_id_r, best_id_nxt;
  logic [IDX_W-1:0]  sel_r, sel_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  job_t              job_r, job_nxt;
  dep_t              out_r, out_nxt;

  logic [CFG_W:0]          cfg_ext;
  logic [CNT_W-1:0]        lim;
  logic                    idle_found;
  logic [IDX_W-1:0]        idle_idx;
  logic [IDX_W-1:0]        rd_addr;
  logic                    scan_issue;
  logic                    cmp_ok;
  logic                    out_free;
  logic [NUM_COUNTERS-1:0] best_hot;
  logic [NUM_COUNTERS-1:0] remain;
  logic [TIME_W:0]         sum;
  logic [TIME_W-1:0]       finish;
  logic                    mem_we;

  assign cfg_ext = {1'b0, cfg_limit};
  always_comb begin
    if (cfg_limit == '0) begin
      lim = CNT_W'(1);
    end else if (cfg_ext > (CFG_W+1)'(NUM_COUNTERS)) begin
      lim = CNT_W'(NUM_COUNTERS);
    end else begin
      lim = CNT_W'(cfg_limit);
    end
  end

  // lowest idle counter below the limit
  always_comb begin
    idle_found = 1'b0;
    idle_idx   = '0;
    for (int i = NUM_COUNTERS - 1; i >= 0; i--) begin
      if (!busy_r[i] && (CNT_W'(i) < lim)) begin
        idle_found = 1'b1;
        idle_idx   = IDX_W'(i);
      end
    end
  end

  assign rd_addr    = rd_cnt_r[IDX_W-1:0];
  assign scan_issue = (state_r == S_SCAN) && (rd_cnt_r != scan_end_r);
  assign cmp_ok     = cmp_v_r && (!fl_r || busy_r[cmp_idx_r]) &&
                      (!have_r || (rd_time_r < best_time_r));
  assign out_free   = !out_valid_r || out_ready;

  always_comb begin
    best_hot             = '0;
    best_hot[best_idx_r] = 1'b1;
  end
  assign remain = busy_r & ~best_hot;

  assign sum    = {1'b0, start_r} + (TIME_W+1)'(job_r.svc);
  assign finish = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  assign mem_we = (state_r == S_WRITE);

  assign q_ready   = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_dep   = out_r;

  always_comb begin
    state_nxt     = state_r;
    busy_nxt      = busy_r;
    fl_nxt        = fl_r;
    rd_cnt_nxt    = rd_cnt_r;
    scan_end_nxt  = scan_end_r;
    cmp_v_nxt     = scan_issue;
    cmp_idx_nxt   = rd_addr;
    have_nxt      = have_r;
    best_time_nxt = best_time_r;
    best_idx_nxt  = best_idx_r;
    best_id_nxt   = best_id_r;
    sel_nxt       = sel_r;
    start_nxt     = start_r;
    job_nxt       = job_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    if (scan_issue) begin
      rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
    end
    if (cmp_ok) begin
      have_nxt      = 1'b1;
      best_time_nxt = rd_time_r;
      best_idx_nxt  = cmp_idx_r;
      best_id_nxt   = rd_id_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          job_nxt = q_job;
          if (idle_found) begin
            sel_nxt   = idle_idx;
            start_nxt = '0;
            state_nxt = S_WRITE;
          end else begin
            fl_nxt       = 1'b0;
            rd_cnt_nxt   = '0;
            scan_end_nxt = lim;
            have_nxt     = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (!scan_issue && !cmp_v_r) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_nxt.fin_time = best_time_r;
          out_nxt.idx      = OIDX_W'(best_idx_r);
          out_nxt.id       = best_id_r;
          if (fl_r) begin
            out_nxt.last = (remain == '0);
            busy_nxt     = remain;
            if (remain == '0) begin
              fl_nxt    = 1'b0;
              state_nxt = S_IDLE;
            end else begin
              rd_cnt_nxt = '0;
              have_nxt   = 1'b0;
              state_nxt  = S_SCAN;
            end
          end else begin
            out_nxt.last = 1'b0;
            start_nxt    = best_time_r;
            sel_nxt      = best_idx_r;
            state_nxt    = S_WRITE;
          end
        end
      end
      S_WRITE: begin
        busy_nxt[sel_r] = 1'b1;
        if (job_r.last) begin
          fl_nxt       = 1'b1;
          rd_cnt_nxt   = '0;
          scan_end_nxt = CNT_W'(NUM_COUNTERS);
          have_nxt     = 1'b0;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      busy_r      <= '0;
      fl_r        <= 1'b0;
      rd_cnt_r    <= '0;
      scan_end_r  <= '0;
      cmp_v_r     <= 1'b0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= busy_nxt;
      fl_r        <= fl_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      scan_end_r  <= scan_end_nxt;
      cmp_v_r     <= cmp_v_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r   <= cmp_idx_nxt;
    best_time_r <= best_time_nxt;
    best_idx_r  <= best_idx_nxt;
    best_id_r   <= best_id_nxt;
    sel_r       <= sel_nxt;
    start_r     <= start_nxt;
    job_r       <= job_nxt;
    out_r       <= out_nxt;
  end

  // counter table, one read and one write port
  always_ff @(posedge clk) begin
    if (scan_issue) begin
      rd_time_r <= time_mem[rd_addr];
      rd_id_r   <= id_mem[rd_addr];
    end
    if (mem_we) begin
      time_mem[sel_r] <= finish;
      id_mem[sel_r]   <= job_r.id;
    end
  end

  a_write_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRITE) |=> busy_r[$past(sel_r)])
    else $error("placed counter not marked busy");

  a_emit_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> have_r)
    else $error("departure emitted without a selected counter");

  a_flush_clears_all: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == S_EMIT && state_r == S_IDLE) |-> (busy_r == '0 && out_r.last))
    else $error("flush ended with busy counters or unmarked final word");

  a_scan_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (rd_cnt_r <= scan_end_r))
    else $error("scan ran past its end");

endmodule
`default_nettype wire

@@ hw/rtl/earliest_free_counter_dispatcher.sv @@
// Top level of the earliest-free counter dispatcher: ports, limit register, front queue, engine.
//
//   channel  | dir | handshake            | payload
//   in_      | in  | in_tvalid/in_tready  | in_tdata: customer_id, service_time; in_tlast: last_job
//   out_     | out | out_tvalid/out_tready| out_tdata: finish_time, counter_index, departing_id;
//            |     |                      | out_tlast: last_departure
//   cfg_     | in  | cfg_we               | cfg_wdata: active_counters
//
// A job that finds an idle counter below the limit goes straight to the write state, with no scan.
// Otherwise the engine scans the limit's counters one a cycle through the table's
// read port and emits one departure word.
// A last job then drains every busy counter, rescanning the whole table for each departure.
// Synchronous reset idles all counters at once; no clearing pass.
// A full output register stalls the engine; the two-entry queue keeps taking words meanwhile until it is full.
`default_nettype none
module earliest_free_counter_dispatcher #(
  parameter int NUM_COUNTERS = 32
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [efcd_pkg::IN_TDATA_W-1:0]    in_tdata,   // customer_id, service_time, pad
  input  wire logic                               in_tlast,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [efcd_pkg::OUT_TDATA_W-1:0]        out_tdata,  // finish_time, counter_index,
                                                              // departing_id, pad
  output logic                                    out_tlast,
  input  wire logic                               cfg_we,
  input  wire logic [efcd_pkg::CFG_W-1:0]         cfg_wdata
);
  import efcd_pkg::*;

  logic [CFG_W-1:0] limit_r;
  logic             q_valid;
  logic             q_ready;
  job_t             q_job;
  dep_t             dep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= CFG_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  efcd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_ready   (q_ready)
  );

  efcd_engine #(
    .NUM_COUNTERS (NUM_COUNTERS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_limit (limit_r),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .q_ready   (q_ready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_dep   (dep)
  );

  assign out_tdata = {(OUT_TDATA_W-TIME_W-OIDX_W-ID_W)'(0), dep.id, dep.idx, dep.fin_time};
  assign out_tlast = dep.last;

endmodule
`default_nettype wire

@@ dv/earliest_free_counter_dispatcher_test.sv @@
// Self-checking testbench for the earliest-free counter dispatcher: directed and random job streams.
module earliest_free_counter_dispatcher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import efcd_pkg::*;

  localparam int NUM_CTR       = 32;
  localparam int SETTLE_CYCLES = 80;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam logic [TIME_W-1:0] TIME_SAT = '1;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   cfg_we     = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata  = CFG_RESET;

  // dispatcher state as predicted
  logic [TIME_W-1:0] free_at [NUM_CTR];
  logic [ID_W-1:0]   holder  [NUM_CTR];
  logic              engaged [NUM_CTR];
  logic [CFG_W-1:0]  limit_reg = CFG_RESET;
  dep_t              departures_due[$];

  bit in_live   = 1'b0;
  bit gaps_on   = 1'b1;
  int errors    = 0;
  int jobs_sent = 0;
  int words_seen = 0;
  int cfg_writes = 0;
  int flushes   = 0;
  int cycles    = 0;
  int ready_hold = 0;

  earliest_free_counter_dispatcher #(.NUM_COUNTERS(NUM_CTR)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** earliest_free_counter_dispatcher: FAILED **");
      $finish;
    end
  end

  function automatic void expect_word(input dep_t d);
    departures_due.insert(departures_due.size(), d);
  endfunction

  // predicted departures for one accepted job
  function automatic void place_job(input logic [ID_W-1:0] id, input logic [SVC_W-1:0] svc,
                                    input logic last);
    int lim;
    int pick;
    int best;
    bit found;
    bit have_pend;
    logic [TIME_W:0] sum;
    logic [TIME_W-1:0] start;
    dep_t d;
    dep_t pend;
    lim = limit_reg;
    if (lim == 0) lim = 1;
    if (lim > NUM_CTR) lim = NUM_CTR;
    found = 1'b0;
    pick = 0;
    for (int i = 0; i < lim; i++) begin
      if (!found && !engaged[i]) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      for (int i = 1; i < lim; i++) begin
        if (free_at[i] < free_at[pick]) pick = i;
      end
    end
    if (engaged[pick]) begin
      d.fin_time = free_at[pick];
      d.idx      = pick[OIDX_W-1:0];
      d.id       = holder[pick];
      d.last     = 1'b0;
      expect_word(d);
      start = free_at[pick];
    end else begin
      start = '0;
    end
    sum = {1'b0, start} + svc;
    free_at[pick] = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
    holder[pick]  = id;
    engaged[pick] = 1'b1;
    if (last) begin
      flushes++;
      have_pend = 1'b0;
      forever begin
        best = -1;
        for (int i = 0; i < NUM_CTR; i++) begin
          if (engaged[i] && (best < 0 || free_at[i] < free_at[best])) best = i;
        end
        if (best < 0) break;
        if (have_pend) expect_word(pend);
        pend.fin_time = free_at[best];
        pend.idx      = best[OIDX_W-1:0];
        pend.id       = holder[best];
        pend.last     = 1'b0;
        have_pend     = 1'b1;
        engaged[best] = 1'b0;
        free_at[best] = '0;
        holder[best]  = '0;
      end
      pend.last = 1'b1;
      expect_word(pend);
    end
  endfunction

  task automatic send_job(input logic [ID_W-1:0] id, input logic [SVC_W-1:0] svc,
                          input logic last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      if (in_live) begin
        in_tvalid <= 1'b0;
        in_live = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_live = 1'b1;
    in_tdata <= {{(IN_TDATA_W-ID_W-SVC_W){1'b0}}, svc, id};
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    place_job(id, svc, last);
    jobs_sent++;
  endtask

  task automatic wait_drained();
    if (in_live) begin
      in_tvalid <= 1'b0;
      in_live = 1'b0;
    end
    while (departures_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    limit_reg = value;
    cfg_writes++;
  endtask

  // result side: check each word, then, while gaps are on, may drop out_tready at random
  always @(posedge clk) begin : result_side
    int w;
    dep_t d;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (departures_due.size() == 0) begin
        $error("departure word with none expected: %h last %b", out_tdata, out_tlast);
        errors++;
      end else begin
        d = departures_due.pop_front();
        if (out_tdata[31:0] !== d.fin_time) begin
          $error("finish_time: expected %0d, got %0d", d.fin_time, out_tdata[31:0]);
          errors++;
        end
        if (out_tdata[36:32] !== d.idx) begin
          $error("counter_index: expected %0d, got %0d", d.idx, out_tdata[36:32]);
          errors++;
        end
        if (out_tdata[56:37] !== d.id) begin
          $error("departing_id: expected %h, got %h", d.id, out_tdata[56:37]);
          errors++;
        end
        if (out_tlast !== d.last) begin
          $error("last_departure: expected %b, got %b", d.last, out_tlast);
          errors++;
        end
      end
      w = gaps_on ? $urandom_range(0, 14) : 0;
      if (w > 0) begin
        out_tready <= 1'b0;
        ready_hold <= w;
      end
    end else if (!out_tready) begin
      if (ready_hold <= 1) out_tready <= 1'b1;
      ready_hold <= ready_hold - 1;
    end
  end

  task automatic test_fill_and_flush();
    send_job(20'h00000, 16'h0000, 1'b0);
    send_job(20'hFFFFF, 16'hFFFF, 1'b0);
    send_job(20'h5A5A5, 16'h8000, 1'b1);
    send_job(20'h00001, 16'h0007, 1'b1);
  endtask

  task automatic test_ties_and_displacement();
    write_limit(6'd3);
    send_job(20'h00010, 16'd100, 1'b0);
    send_job(20'h00011, 16'd100, 1'b0);
    send_job(20'h00012, 16'd100, 1'b0);
    send_job(20'h00013, 16'd50, 1'b0);
    send_job(20'h00014, 16'd0, 1'b0);
    send_job(20'h00015, 16'd10, 1'b0);
    send_job(20'h00016, 16'd0, 1'b1);
  endtask

  task automatic test_limit_extremes();
    write_limit(6'd0);   // behaves as one counter
    send_job(20'h00020, 16'd5, 1'b0);
    send_job(20'h00021, 16'd6, 1'b0);
    send_job(20'h00022, 16'd7, 1'b1);
    write_limit(6'd63);  // clamps to the built count
    send_job(20'h00023, 16'd1, 1'b0);
    send_job(20'h00024, 16'd2, 1'b1);
    write_limit(6'd33);
    send_job(20'h00025, 16'd3, 1'b1);
  endtask

  task automatic test_limit_lowered_mid_batch();
    write_limit(6'd4);
    send_job(20'h00030, 16'd40, 1'b0);
    send_job(20'h00031, 16'd30, 1'b0);
    send_job(20'h00032, 16'd20, 1'b0);
    send_job(20'h00033, 16'd10, 1'b0);
    write_limit(6'd2);   // counters 2 and 3 keep their jobs until the flush
    send_job(20'h00034, 16'd5, 1'b0);
    send_job(20'h00035, 16'd5, 1'b0);
    send_job(20'h00036, 16'd5, 1'b1);
  endtask

  // one counter, maximal service times back to back, finish times well past 16 bits
  task automatic test_long_chain();
    write_limit(6'd1);
    gaps_on = 1'b0;
    for (int k = 0; k < 12; k++) send_job(ID_W'($urandom), 16'hFFFF, 1'b0);
    send_job(ID_W'($urandom), 16'd1, 1'b0);
    send_job(ID_W'($urandom), 16'd0, 1'b1);
    wait_drained();
    gaps_on = 1'b1;
  endtask

  task automatic test_random_batches();
    int sent;
    int blen;
    logic [SVC_W-1:0] svc;
    logic [CFG_W-1:0] lim;
    sent = 0;
    while (sent < 64) begin
      gaps_on = ($urandom_range(0, 9) < 7);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       lim = 6'd0;
          1:       lim = $urandom_range(0, 1) ? 6'd63 : 6'd32;
          2:       lim = CFG_W'($urandom_range(33, 63));
          default: lim = CFG_W'($urandom_range(1, 6));
        endcase
        write_limit(lim);
      end
      blen = $urandom_range(1, 16);
      for (int j = 0; j < blen; j++) begin
        if (j > 0 && $urandom_range(0, 11) == 0) begin
          if ($urandom_range(0, 1)) write_limit(CFG_W'($urandom_range(0, 8)));
          else wait_drained();
        end
        case ($urandom_range(0, 3))
          0:       svc = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
          1:       svc = SVC_W'($urandom_range(0, 20));
          default: svc = SVC_W'($urandom);
        endcase
        send_job(ID_W'($urandom), svc, j == blen - 1);
        sent++;
      end
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < NUM_CTR; i++) begin
      free_at[i] = '0;
      holder[i]  = '0;
      engaged[i] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_fill_and_flush();
    test_ties_and_displacement();
    test_limit_extremes();
    test_limit_lowered_mid_batch();
    test_long_chain();
    test_random_batches();
    wait_drained();
    $display("Run covered %0d jobs in %0d flushed batches, %0d departure words checked,",
             jobs_sent, flushes, words_seen);
    $display("%0d limit writes including zero and clamped values, and long one-counter chains.",
             cfg_writes);
    if (errors == 0) begin
      $display("** earliest_free_counter_dispatcher: PASSED **");
    end else begin
      $display("** earliest_free_counter_dispatcher: FAILED **");
    end
    $finish;
  end

endmodule
